@@ hw/rtl/cpft_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the Clarke/Park frame transform core.
// Holds the transaction structs, stage bundles and datapath widths; no dependencies.
package cpft_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int ANGLE_WIDTH  = 16;

  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  localparam int SUM_W       = 18;
  localparam int XY_W        = 18;
  localparam int BETA_PROD_W = 36;
  localparam int PROD_W      = 34;
  localparam int ROT_SUM_W   = 35;
  localparam int ROT_W       = 20;
  localparam int ICL_W       = 38;
  localparam int SAT_IN_W    = 22;

  localparam int PIPE_LATENCY = 7;

  localparam logic signed [17:0] INV_SQRT3_Q16  = 18'sd37837;
  localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;

  typedef struct packed {
    logic                           operation;
    logic signed [SAMPLE_WIDTH-1:0] value_one;
    logic signed [SAMPLE_WIDTH-1:0] value_two;
    logic [ANGLE_WIDTH-1:0]         angle;
  } cpft_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_first;
    logic signed [SAMPLE_WIDTH-1:0] out_second;
    logic signed [SAMPLE_WIDTH-1:0] out_third;
  } cpft_out_t;

  typedef struct packed {
    logic                           valid;
    logic                           op;
    logic signed [XY_W-1:0]         x;
    logic signed [XY_W-1:0]         y;
    logic signed [SAMPLE_WIDTH-1:0] sine;
    logic signed [SAMPLE_WIDTH-1:0] cosine;
  } cpft_xy_t;

  typedef struct packed {
    logic                    valid;
    logic                    op;
    logic signed [ROT_W-1:0] first;
    logic signed [ROT_W-1:0] second;
  } cpft_rot_t;

endpackage

@@ hw/rtl/cpft_sine_rom.sv @@
`timescale 1ns / 1ps
// Dual-read sine ROM, one entry per step of a full turn, Q1.15 with registered reads.
// Depends on cpft_pkg for sample and angle widths.
module cpft_sine_rom
  import cpft_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                           clk,
  input  logic [ANGLE_WIDTH-1:0]         angle,
  output logic signed [SAMPLE_WIDTH-1:0] sine,
  output logic signed [SAMPLE_WIDTH-1:0] cosine
);

  localparam int  TABLE_SIZE   = 1 << SINE_TABLE_BITS;
  localparam int  QUARTER      = 1 << (SINE_TABLE_BITS - 2);
  localparam int  SAMPLE_MAX   = (1 << (SAMPLE_WIDTH - 1)) - 1;
  localparam real HALF_PI      = 1.5707963267948966;
  localparam real SINE_SCALE   = 32768.0;
  localparam real QUARTER_STEP = 2.0 ** (2 - SINE_TABLE_BITS);

  typedef logic signed [SAMPLE_WIDTH-1:0] rom_array_t [TABLE_SIZE];

  function automatic logic signed [SAMPLE_WIDTH-1:0] quarter_value(int r);
    real v;
    int  q;
    v = SINE_SCALE * $sin(HALF_PI * real'(r) * QUARTER_STEP);
    q = int'($floor(v + 0.5));
    if (q > SAMPLE_MAX) begin
      q = SAMPLE_MAX;
    end
    return SAMPLE_WIDTH'(q);
  endfunction

  function automatic rom_array_t build_rom();
    rom_array_t                     rom;
    int                             quad;
    int                             m;
    logic signed [SAMPLE_WIDTH-1:0] v;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      quad = k >> (SINE_TABLE_BITS - 2);
      m    = k & (QUARTER - 1);
      v    = quad[0] ? quarter_value(QUARTER - m) : quarter_value(m);
      rom[k] = quad[1] ? -v : v;
    end
    return rom;
  endfunction

  localparam rom_array_t ROM = build_rom();

  logic [SINE_TABLE_BITS-1:0] sin_idx;
  logic [SINE_TABLE_BITS-1:0] cos_idx;

  assign sin_idx = angle[ANGLE_WIDTH-1 -: SINE_TABLE_BITS];
  assign cos_idx = sin_idx + SINE_TABLE_BITS'(QUARTER);

  always_ff @(posedge clk) begin
    sine   <= ROM[sin_idx];
    cosine <= ROM[cos_idx];
  end

endmodule

@@ hw/rtl/cpft_clarke.sv @@
`timescale 1ns / 1ps
// Input stages: register the transaction, form the forward Clarke beta, align trig values.
// Depends on cpft_pkg; takes sine and cosine from cpft_sine_rom in the cycle after accept.
module cpft_clarke
  import cpft_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  cpft_in_t                       cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] sine,
  input  logic signed [SAMPLE_WIDTH-1:0] cosine,
  output cpft_xy_t                       xy
);

  logic                           valid1;
  logic                           op1;
  logic signed [SAMPLE_WIDTH-1:0] v1_1;
  logic signed [SAMPLE_WIDTH-1:0] v2_1;
  logic signed [SUM_W-1:0]        sum1;

  logic                           valid2;
  logic                           op2;
  logic signed [SAMPLE_WIDTH-1:0] v1_2;
  logic signed [SAMPLE_WIDTH-1:0] v2_2;
  logic signed [BETA_PROD_W-1:0]  prod2;
  logic signed [SAMPLE_WIDTH-1:0] sine2;
  logic signed [SAMPLE_WIDTH-1:0] cosine2;

  logic signed [SUM_W-1:0]        sum_next;
  logic signed [BETA_PROD_W-1:0]  beta_round;

  assign sum_next   = SUM_W'(cmd.value_one) + (SUM_W'(cmd.value_two) <<< 1);
  assign beta_round = prod2 + BETA_PROD_W'(32768);

  always_ff @(posedge clk) begin
    valid1 <= accept;
    op1    <= cmd.operation;
    v1_1   <= cmd.value_one;
    v2_1   <= cmd.value_two;
    sum1   <= sum_next;

    valid2  <= valid1;
    op2     <= op1;
    v1_2    <= v1_1;
    v2_2    <= v2_1;
    prod2   <= BETA_PROD_W'(sum1) * BETA_PROD_W'(INV_SQRT3_Q16);
    sine2   <= sine;
    cosine2 <= cosine;

    xy.valid  <= valid2;
    xy.op     <= op2;
    xy.x      <= XY_W'(v1_2);
    xy.y      <= (op2 == OP_INVERSE) ? XY_W'(v2_2) : beta_round[XY_W+15:16];
    xy.sine   <= sine2;
    xy.cosine <= cosine2;

    if (rst) begin
      valid1   <= 1'b0;
      valid2   <= 1'b0;
      xy.valid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/cpft_rotate.sv @@
`timescale 1ns / 1ps
// Rotation stages: four products of x and y with sine and cosine, then rounded sums.
// Serves forward Park and inverse Park; depends on cpft_pkg.
module cpft_rotate
  import cpft_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cpft_xy_t  xy,
  output cpft_rot_t rot
);

  logic                     valid4;
  logic                     op4;
  logic signed [PROD_W-1:0] p_xc;
  logic signed [PROD_W-1:0] p_ys;
  logic signed [PROD_W-1:0] p_yc;
  logic signed [PROD_W-1:0] p_xs;

  logic signed [ROT_SUM_W-1:0] sum_first;
  logic signed [ROT_SUM_W-1:0] sum_second;
  logic signed [ROT_SUM_W-1:0] rnd_first;
  logic signed [ROT_SUM_W-1:0] rnd_second;

  always_comb begin
    if (op4 == OP_INVERSE) begin
      sum_first  = ROT_SUM_W'(p_xc) - ROT_SUM_W'(p_ys);
      sum_second = ROT_SUM_W'(p_xs) + ROT_SUM_W'(p_yc);
    end else begin
      sum_first  = ROT_SUM_W'(p_xc) + ROT_SUM_W'(p_ys);
      sum_second = ROT_SUM_W'(p_yc) - ROT_SUM_W'(p_xs);
    end
    rnd_first  = sum_first + ROT_SUM_W'(16384);
    rnd_second = sum_second + ROT_SUM_W'(16384);
  end

  always_ff @(posedge clk) begin
    valid4 <= xy.valid;
    op4    <= xy.op;
    p_xc   <= PROD_W'(xy.x) * PROD_W'(xy.cosine);
    p_ys   <= PROD_W'(xy.y) * PROD_W'(xy.sine);
    p_yc   <= PROD_W'(xy.y) * PROD_W'(xy.cosine);
    p_xs   <= PROD_W'(xy.x) * PROD_W'(xy.sine);

    rot.valid  <= valid4;
    rot.op     <= op4;
    rot.first  <= rnd_first[ROT_W+14:15];
    rot.second <= rnd_second[ROT_W+14:15];

    if (rst) begin
      valid4    <= 1'b0;
      rot.valid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/cpft_output_stage.sv @@
`timescale 1ns / 1ps
// Output stages: inverse Clarke for phases b and c, saturation, result register and strobe.
// Depends on cpft_pkg; fed by cpft_rotate.
module cpft_output_stage
  import cpft_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cpft_rot_t rot,
  output logic      done,
  output cpft_out_t result
);

  localparam logic signed [SAT_IN_W-1:0] SAT_HI =
    SAT_IN_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);

  function automatic logic signed [SAMPLE_WIDTH-1:0] saturate(
    logic signed [SAT_IN_W-1:0] v
  );
    if (v > SAT_HI) begin
      return SAT_HI[SAMPLE_WIDTH-1:0];
    end
    if (v < SAT_LO) begin
      return SAT_LO[SAMPLE_WIDTH-1:0];
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  logic                    valid6;
  logic                    op6;
  logic signed [ROT_W-1:0] first6;
  logic signed [ROT_W-1:0] second6;
  logic signed [ICL_W-1:0] bterm6;

  logic signed [ICL_W-1:0] aterm;
  logic signed [ICL_W-1:0] b_sum;
  logic signed [ICL_W-1:0] c_sum;

  assign aterm = ICL_W'(first6) <<< 15;
  assign b_sum = bterm6 - aterm + ICL_W'(32768);
  assign c_sum = -aterm - bterm6 + ICL_W'(32768);

  always_ff @(posedge clk) begin
    valid6  <= rot.valid;
    op6     <= rot.op;
    first6  <= rot.first;
    second6 <= rot.second;
    bterm6  <= ICL_W'(rot.second) * ICL_W'(SQRT3_HALF_Q16);

    done              <= valid6;
    result.out_first  <= saturate(SAT_IN_W'(first6));
    if (op6 == OP_INVERSE) begin
      result.out_second <= saturate(b_sum[SAT_IN_W+15:16]);
      result.out_third  <= saturate(c_sum[SAT_IN_W+15:16]);
    end else begin
      result.out_second <= saturate(SAT_IN_W'(second6));
      result.out_third  <= '0;
    end

    if (rst) begin
      valid6 <= 1'b0;
      done   <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/clarke_park_frame_transform_core.sv @@
`timescale 1ns / 1ps
// Top level of the Clarke/Park frame transform core.
// Depends on cpft_pkg, cpft_sine_rom, cpft_clarke, cpft_rotate and cpft_output_stage.
//
// The core takes one transaction on every clock: busy stays low, so a transaction is
// accepted at every edge where start is high. Each result appears on result for one
// cycle with done high, in the order the transactions were accepted.
// The receiver cannot stall, so capture result whenever done is high. Rate is one
// transaction per cycle, set by a seven-stage pipeline with at most one multiplier level
// per stage and a sine ROM with two registered read ports (sine and cosine in the same
// cycle). The ROM holds 2^SINE_TABLE_BITS Q1.15 entries, fixed at elaboration, so no
// fill or clearing pass follows reset. Operation 0 maps phases a and b to d and q;
// operation 1 maps d and q to phases a, b and c. All results saturate to 16 bits.
module clarke_park_frame_transform_core
  import cpft_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  cpft_in_t  cmd,
  output logic      done,
  output cpft_out_t result
);

  logic                           accept;
  logic signed [SAMPLE_WIDTH-1:0] sine;
  logic signed [SAMPLE_WIDTH-1:0] cosine;
  cpft_xy_t                       xy;
  cpft_rot_t                      rot;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  cpft_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk   (clk),
    .angle (cmd.angle),
    .sine  (sine),
    .cosine(cosine)
  );

  cpft_clarke u_clarke (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .cmd   (cmd),
    .sine  (sine),
    .cosine(cosine),
    .xy    (xy)
  );

  cpft_rotate u_rotate (
    .clk(clk),
    .rst(rst),
    .xy (xy),
    .rot(rot)
  );

  cpft_output_stage u_output (
    .clk   (clk),
    .rst   (rst),
    .rot   (rot),
    .done  (done),
    .result(result)
  );

endmodule

@@ hw/rtl/cpft_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the Clarke/Park frame transform core, bound to the top level.
// Depends on cpft_pkg for the transaction types and the pipeline latency.
module cpft_checker
  import cpft_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input cpft_in_t  cmd,
  input logic      done,
  input cpft_out_t result
);

  a_result_follows: assert property (
    @(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done
  ) else $error("accepted transaction produced no result");

  a_no_spurious_result: assert property (
    @(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY)
  ) else $error("result strobe without a matching transaction");

  a_forward_third_zero: assert property (
    @(posedge clk) disable iff (rst)
    (done && $past(cmd.operation == OP_FORWARD, PIPE_LATENCY))
      |-> (result.out_third == '0)
  ) else $error("forward transaction gave nonzero third output");

endmodule

bind clarke_park_frame_transform_core cpft_checker u_checker (.*);

@@ dv/clarke_park_frame_transform_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for clarke_park_frame_transform_core: forward and inverse frame
// transforms, predicted from a bit-exact sine table and fixed-point datapath of its own.
// Depends on cpft_pkg and the core RTL only.
module clarke_park_frame_transform_core_test;
  import cpft_pkg::*;

  localparam int TABLE_BITS = 10;
  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int QUARTER    = 1 << (TABLE_BITS - 2);
  localparam longint unsigned HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam longint unsigned UNITY_Q62   = 64'h4000000000000000;
  localparam int CYCLE_LIMIT = 50000;
  localparam int RANDOM_ITEMS = 630;

  typedef struct {
    cpft_in_t    payload;
    int unsigned idle_pct;
    bit          drain;
  } pending_cmd_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  cpft_in_t  cmd = '0;
  logic      done;
  cpft_out_t result;

  pending_cmd_t pending_cmds[$];
  cpft_out_t    expected_frames[$];
  cpft_out_t    want;
  longint       sine_lut[TABLE_SIZE];
  int           frames_owed = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  clarke_park_frame_transform_core #(
    .SINE_TABLE_BITS(TABLE_BITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned q62_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic longint quarter_sine(int unsigned m);
    bit use_cos;
    longint unsigned r, x, x2, t, s, div;
    use_cos = m > QUARTER / 2;
    r = use_cos ? QUARTER - m : m;
    x = q62_mul(HALF_PI_Q62, r << (64 - TABLE_BITS));
    x2 = q62_mul(x, x);
    t = use_cos ? UNITY_Q62 : x;
    s = t;
    for (longint unsigned k = 1; k <= 14; k++) begin
      div = use_cos ? (2 * k - 1) * (2 * k) : (2 * k) * (2 * k + 1);
      t = q62_mul(t, x2) / div;
      if (k[0]) s = s - t;
      else s = s + t;
    end
    s = (s + (64'd1 << 46)) >> 47;
    if (s > 32767) s = 32767;
    return longint'(s);
  endfunction

  function automatic longint round_up_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] clamp_sample(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic cpft_out_t frame_transform(cpft_in_t c);
    cpft_out_t r;
    int unsigned idx;
    longint sn, cs, v1, v2, alpha, beta;
    idx = c.angle >> (ANGLE_WIDTH - TABLE_BITS);
    sn = sine_lut[idx];
    cs = sine_lut[(idx + QUARTER) % TABLE_SIZE];
    v1 = longint'(c.value_one);
    v2 = longint'(c.value_two);
    if (c.operation == OP_FORWARD) begin
      alpha = v1;
      beta = round_up_shift((v1 + 2 * v2) * longint'(INV_SQRT3_Q16), 16);
      r.out_first  = clamp_sample(round_up_shift(alpha * cs + beta * sn, 15));
      r.out_second = clamp_sample(round_up_shift(beta * cs - alpha * sn, 15));
      r.out_third  = '0;
    end else begin
      alpha = round_up_shift(v1 * cs - v2 * sn, 15);
      beta = round_up_shift(v1 * sn + v2 * cs, 15);
      r.out_first  = clamp_sample(alpha);
      r.out_second = clamp_sample(round_up_shift(-alpha * 32768 +
                                                 beta * longint'(SQRT3_HALF_Q16), 16));
      r.out_third  = clamp_sample(round_up_shift(-alpha * 32768 -
                                                 beta * longint'(SQRT3_HALF_Q16), 16));
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ANGLE_WIDTH-1:0] random_angle();
    if ($urandom_range(0, 7) == 0)
      return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 127)) - 16'd64;
    return 16'($urandom);
  endfunction

  task automatic queue_cmd(logic op, logic signed [15:0] v1, logic signed [15:0] v2,
                           logic [15:0] ang, int unsigned idle, bit drain);
    pending_cmd_t p;
    p.payload.operation = op;
    p.payload.value_one = v1;
    p.payload.value_two = v2;
    p.payload.angle     = ang;
    p.idle_pct = idle;
    p.drain    = drain;
    pending_cmds.push_back(p);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_cmds.size() != 0 &&
          !(pending_cmds[0].drain && (start || frames_owed != 0)) &&
          $urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
        cmd   <= pending_cmds[0].payload;
        start <= 1'b1;
        void'(pending_cmds.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) expected_frames.push_back(frame_transform(cmd));
      if (done) begin
        if (expected_frames.size() == 0) begin
          $error("result with no transaction outstanding");
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          if (result.out_first !== want.out_first) begin
            $error("out_first: expected %0d, actual %0d", want.out_first, result.out_first);
            mismatches++;
          end
          if (result.out_second !== want.out_second) begin
            $error("out_second: expected %0d, actual %0d", want.out_second,
                   result.out_second);
            mismatches++;
          end
          if (result.out_third !== want.out_third) begin
            $error("out_third: expected %0d, actual %0d", want.out_third, result.out_third);
            mismatches++;
          end
        end
      end
      frames_owed <= expected_frames.size();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned idle;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      if ((k >> (TABLE_BITS - 2)) & 1)
        sine_lut[k] = quarter_sine(QUARTER - (k & (QUARTER - 1)));
      else
        sine_lut[k] = quarter_sine(k & (QUARTER - 1));
      if ((k >> (TABLE_BITS - 2)) & 2) sine_lut[k] = -sine_lut[k];
    end

    queue_cmd(OP_FORWARD, 16'sd0, 16'sd0, 16'h0000, 6, 0);
    queue_cmd(OP_FORWARD, 16'sd32767, 16'sd0, 16'h0000, 6, 0);
    queue_cmd(OP_FORWARD, 16'sd32767, 16'sd32767, 16'h2000, 6, 0);
    queue_cmd(OP_FORWARD, -16'sd32768, -16'sd32768, 16'h2000, 6, 0);
    queue_cmd(OP_FORWARD, 16'sd32767, -16'sd32768, 16'h4000, 6, 0);
    queue_cmd(OP_FORWARD, -16'sd32768, 16'sd32767, 16'h8000, 6, 0);
    queue_cmd(OP_FORWARD, 16'sd12345, -16'sd9876, 16'hC000, 6, 0);
    queue_cmd(OP_FORWARD, -16'sd1, 16'sd1, 16'hFFFF, 6, 0);
    queue_cmd(OP_FORWARD, 16'sd20000, 16'sd20000, 16'h003F, 6, 0);
    queue_cmd(OP_FORWARD, 16'sd20000, 16'sd20000, 16'h0040, 6, 0);
    queue_cmd(OP_INVERSE, 16'sd0, 16'sd0, 16'h0000, 6, 0);
    queue_cmd(OP_INVERSE, 16'sd32767, 16'sd0, 16'h0000, 6, 0);
    queue_cmd(OP_INVERSE, 16'sd32767, 16'sd32767, 16'h2000, 6, 0);
    queue_cmd(OP_INVERSE, -16'sd32768, -16'sd32768, 16'h2000, 6, 0);
    queue_cmd(OP_INVERSE, -16'sd32768, -16'sd32768, 16'hA000, 6, 0);
    queue_cmd(OP_INVERSE, 16'sd32767, -16'sd32768, 16'h4000, 6, 0);
    queue_cmd(OP_INVERSE, -16'sd32768, 16'sd32767, 16'h8000, 6, 0);
    queue_cmd(OP_INVERSE, 16'sd32767, 16'sd32767, 16'h5555, 6, 0);
    queue_cmd(OP_INVERSE, -16'sd1, 16'sd1, 16'hFFFF, 6, 0);
    queue_cmd(OP_INVERSE, 16'sd12345, -16'sd9876, 16'hC03F, 6, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle = (i < RANDOM_ITEMS / 3) ? 6 : (i < 2 * RANDOM_ITEMS / 3) ? 52 : 0;
      queue_cmd(1'($urandom), random_sample(), random_sample(), random_angle(), idle,
                (i % 97) == 0 || i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_cmds.size() != 0 || start || frames_owed != 0) @(negedge clk);
    repeat (4 * PIPE_LATENCY) @(negedge clk);

    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ clarke_park_frame_transform_core.f @@
hw/rtl/cpft_pkg.sv
hw/rtl/cpft_sine_rom.sv
hw/rtl/cpft_clarke.sv
hw/rtl/cpft_rotate.sv
hw/rtl/cpft_output_stage.sv
hw/rtl/clarke_park_frame_transform_core.sv
hw/rtl/cpft_checker.sv
dv/clarke_park_frame_transform_core_test.sv
